FILE: hdl/gmn_pkg.sv
// ----------------------------------------------------------------------------
// Gradient magnitude normaliser package
// Shared constants, register indexes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package gmn_pkg;

  localparam int unsigned MaxCols    = 256;
  localparam int unsigned MaxRows    = 256;
  localparam int unsigned DimW       = 9;
  localparam int unsigned LineAw     = 8;
  localparam int unsigned StoreAw    = 16;
  localparam int unsigned StoreDepth = (MaxCols - 2) * (MaxRows - 2);
  localparam int unsigned CfgIdxW    = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;

  // Square root produces one result bit per step, the divider one quotient bit.
  localparam logic [3:0] RootLastStep = 4'd8;
  localparam logic [3:0] DivLastStep  = 4'd7;

  typedef struct packed {
    logic acc_load;
    logic line_rd;
    logic line_cap;
    logic diff;
    logic square;
    logic root_step;
    logic store;
    logic finish;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic interior;
  } status_t;

  // Clamp a geometry register to the supported range of three up to the maximum.
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input logic [DimW-1:0] maxv);
    logic [DimW-1:0] r;
    if (v < DimW'(3)) r = DimW'(3);
    else if (v > maxv) r = maxv;
    else r = v;
    return r;
  endfunction

endpackage

FILE: hdl/gradient_magnitude_normalizer.sv
// ----------------------------------------------------------------------------
// Gradient magnitude normaliser
// Central difference gradient magnitude over one frame, rescaled on fetch.
// ----------------------------------------------------------------------------
// A load item of a border pixel skips the square root; an interior pixel also
// runs the nine steps of the bit-serial square root.
// A fetch item runs the eight steps of the divider; its result is strobed for
// one cycle as busy_o falls, and the receiver cannot stall.
// Reset is asynchronous and active low; frame geometry returns to 256 by 256.
// Line buffers and the frame store are not cleared and need no clearing pass.
module gradient_magnitude_normalizer import gmn_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               action_i,
  input  logic [7:0]         pixel_i,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]    cfg_wdata_i,
  output logic               valid_o,
  output logic [7:0]         magnitude_o,
  output logic               last_o
);

  cmd_t    cmd;
  status_t status;

  // The controller decides what happens each cycle; the datapath holds all
  // frame state, the two line buffers and the frame store.
  gmn_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .action_i (action_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  gmn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .pixel_i     (pixel_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_o    (status),
    .valid_o     (valid_o),
    .magnitude_o (magnitude_o),
    .last_o      (last_o)
  );

  // A result is only ever produced at the end of fetch work.
  a_valid_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  // The block is free again in the cycle its result is shown.
  a_idle_with_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result strobe while still busy");

  // A pixel load never produces a result.
  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !action_i) |=> !valid_o)
    else $error("result after a load item");

endmodule

FILE: hdl/gmn_ctrl.sv
// ----------------------------------------------------------------------------
// Gradient magnitude normaliser controller
// Sequences the load and fetch work of one item through the datapath.
// ----------------------------------------------------------------------------
module gmn_ctrl import gmn_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    action_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StLdRd    = 4'd1;
  localparam logic [3:0] StLdCap   = 4'd2;
  localparam logic [3:0] StLdDiff  = 4'd3;
  localparam logic [3:0] StLdSq    = 4'd4;
  localparam logic [3:0] StLdRoot  = 4'd5;
  localparam logic [3:0] StLdStore = 4'd6;
  localparam logic [3:0] StLdFin   = 4'd7;
  localparam logic [3:0] StFtRd    = 4'd8;
  localparam logic [3:0] StFtInit  = 4'd9;
  localparam logic [3:0] StFtDiv   = 4'd10;
  localparam logic [3:0] StFtOut   = 4'd11;

  logic [3:0] state_q, state_d;
  logic [3:0] step_q, step_d;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          if (!action_i) begin
            cmd_o.acc_load = 1'b1;
            state_d = StLdRd;
          end else if (status_i.ready) begin
            state_d = StFtRd;
          end
        end
      end
      StLdRd: begin
        cmd_o.line_rd = 1'b1;
        state_d = StLdCap;
      end
      StLdCap: begin
        cmd_o.line_cap = 1'b1;
        state_d = StLdDiff;
      end
      StLdDiff: begin
        cmd_o.diff = 1'b1;
        state_d = status_i.interior ? StLdSq : StLdFin;
      end
      StLdSq: begin
        cmd_o.square = 1'b1;
        step_d = '0;
        state_d = StLdRoot;
      end
      StLdRoot: begin
        cmd_o.root_step = 1'b1;
        step_d = step_q + 4'd1;
        if (step_q == RootLastStep) state_d = StLdStore;
      end
      StLdStore: begin
        cmd_o.store = 1'b1;
        state_d = StLdFin;
      end
      StLdFin: begin
        cmd_o.finish = 1'b1;
        state_d = StIdle;
      end
      StFtRd: begin
        state_d = StFtInit;
      end
      StFtInit: begin
        cmd_o.div_init = 1'b1;
        step_d = '0;
        state_d = StFtDiv;
      end
      StFtDiv: begin
        cmd_o.div_step = 1'b1;
        step_d = step_q + 4'd1;
        if (step_q == DivLastStep) state_d = StFtOut;
      end
      StFtOut: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

FILE: hdl/gmn_dp.sv
// ----------------------------------------------------------------------------
// Gradient magnitude normaliser datapath
// Line buffers, frame store, square root and divider, frame counters.
// ----------------------------------------------------------------------------
module gmn_dp import gmn_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [7:0]        pixel_i,
  input  logic              cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DimW-1:0]   cfg_wdata_i,
  output status_t           status_o,
  output logic              valid_o,
  output logic [7:0]        magnitude_o,
  output logic              last_o
);

  logic [DimW-1:0] width_q, height_q, w_use, h_use;
  logic [StoreAw-1:0] count_q;
  logic [DimW-1:0] row_q, col_q;
  logic [7:0] pix_q, held_q, peak_q;
  logic ready_q, sel_q;
  logic [StoreAw-1:0] wptr_q, rptr_q;

  logic [7:0] line0_mem [2**LineAw];
  logic [7:0] line1_mem [2**LineAw];
  logic [7:0] rd0_q, rd1_q;
  logic [7:0] store_mem [2**StoreAw];
  logic [7:0] st_rd_q;

  logic [7:0] nc_q, oc_q, adx_q, ady_q;
  logic [17:0] sq_sh_q;
  logic [11:0] rem_q;
  logic [8:0] root_q;
  logic [7:0] drem_q, dnum_q, quo_q;
  logic valid_q, last_q;
  logic [7:0] mag_q;

  assign w_use = clamp_dim(width_q, DimW'(MaxCols));
  assign h_use = clamp_dim(height_q, DimW'(MaxRows));

  logic last_col, last_row;
  assign last_col = (col_q == w_use - DimW'(1));
  assign last_row = (row_q == h_use - DimW'(1));

  // Line buffer addressing: the newer row is bank 0 when sel_q is low.
  logic [LineAw-1:0] c8, newer_addr, older_addr, addr0, addr1, waddr;
  logic [7:0] wdata, newer_rd, older_rd;
  logic we_older;
  assign c8         = col_q[LineAw-1:0];
  assign newer_addr = cmd_i.line_cap ? c8 - LineAw'(2) : c8;
  assign older_addr = c8 - LineAw'(1);
  assign addr0      = sel_q ? older_addr : newer_addr;
  assign addr1      = sel_q ? newer_addr : older_addr;
  assign we_older   = (cmd_i.line_cap && col_q != '0) || (cmd_i.finish && last_col);
  assign waddr      = cmd_i.line_cap ? older_addr : c8;
  assign wdata      = cmd_i.line_cap ? held_q : pix_q;
  assign newer_rd   = sel_q ? rd1_q : rd0_q;
  assign older_rd   = sel_q ? rd0_q : rd1_q;

  always_ff @(posedge clk_i) begin
    if (we_older && sel_q) line0_mem[waddr] <= wdata;
    if (we_older && !sel_q) line1_mem[waddr] <= wdata;
    if (cmd_i.line_rd || cmd_i.line_cap) begin
      rd0_q <= line0_mem[addr0];
      rd1_q <= line1_mem[addr1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) store_mem[wptr_q] <= root_q[8:1];
    st_rd_q <= store_mem[rptr_q];
  end

  // Square root step: two radicand bits in, one root bit out.
  logic [11:0] rem_n, trial;
  assign rem_n = {rem_q[9:0], sq_sh_q[17:16]};
  assign trial = {1'b0, root_q, 2'b01};

  // Divider step: one quotient bit.
  logic [8:0] dt;
  logic [15:0] num;
  assign dt  = {drem_q, dnum_q[7]};
  assign num = {st_rd_q, 8'h00} - {8'h00, st_rd_q};

  logic [StoreAw:0] rnext;
  assign rnext = {1'b0, rptr_q} + (StoreAw+1)'(1);

  // Load accept: frame restart handling.
  logic [DimW-1:0] row_a, col_a;
  always_comb begin
    row_a = row_q;
    col_a = col_q;
    if (ready_q || row_q >= h_use || col_q >= w_use) begin
      row_a = '0;
      col_a = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_load) pix_q <= pixel_i;
    if (cmd_i.line_cap) begin
      nc_q <= newer_rd;
      oc_q <= older_rd;
    end
    if (cmd_i.diff) begin
      adx_q <= (nc_q >= newer_rd) ? nc_q - newer_rd : newer_rd - nc_q;
      ady_q <= (oc_q >= held_q) ? oc_q - held_q : held_q - oc_q;
    end
    if (cmd_i.square) begin
      sq_sh_q <= 18'({8'h00, adx_q} * {8'h00, adx_q}) + 18'({8'h00, ady_q} * {8'h00, ady_q});
      rem_q   <= '0;
      root_q  <= '0;
    end
    if (cmd_i.root_step) begin
      sq_sh_q <= {sq_sh_q[15:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[7:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[7:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      drem_q <= num[15:8];
      dnum_q <= num[7:0];
      quo_q  <= '0;
    end
    if (cmd_i.div_step) begin
      dnum_q <= {dnum_q[6:0], 1'b0};
      if (dt >= {1'b0, peak_q}) begin
        drem_q <= 8'(dt - {1'b0, peak_q});
        quo_q  <= {quo_q[6:0], 1'b1};
      end else begin
        drem_q <= dt[7:0];
        quo_q  <= {quo_q[6:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      mag_q  <= (peak_q == '0) ? 8'h00 : quo_q;
      last_q <= (rnext >= {1'b0, count_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(MaxCols);
      height_q <= DimW'(MaxRows);
      count_q  <= '0;
      row_q    <= '0;
      col_q    <= '0;
      held_q   <= '0;
      peak_q   <= '0;
      ready_q  <= 1'b0;
      sel_q    <= 1'b0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      valid_q  <= 1'b0;
    end else begin
      count_q <= StoreAw'(w_use - DimW'(2)) * StoreAw'(h_use - DimW'(2));
      valid_q <= cmd_i.emit;
      if (cmd_i.acc_load) begin
        row_q <= row_a;
        col_q <= col_a;
        if (ready_q) begin
          ready_q <= 1'b0;
          rptr_q  <= '0;
        end
        if (row_a == '0 && col_a == '0) begin
          peak_q <= '0;
          wptr_q <= '0;
        end
      end
      if (cmd_i.store) begin
        wptr_q <= wptr_q + StoreAw'(1);
        if (root_q[8:1] > peak_q) peak_q <= root_q[8:1];
      end
      if (cmd_i.finish) begin
        held_q <= pix_q;
        if (last_col) begin
          sel_q <= ~sel_q;
          col_q <= '0;
          if (last_row) begin
            row_q   <= '0;
            ready_q <= 1'b1;
            rptr_q  <= '0;
          end else begin
            row_q <= row_q + DimW'(1);
          end
        end else begin
          col_q <= col_q + DimW'(1);
        end
      end
      if (cmd_i.emit) begin
        if (rnext >= {1'b0, count_q}) begin
          ready_q <= 1'b0;
          rptr_q  <= '0;
        end else begin
          rptr_q <= rnext[StoreAw-1:0];
        end
      end
      if (cfg_we_i && (cfg_index_i == CfgFrameWidth || cfg_index_i == CfgFrameHeight)) begin
        if (cfg_index_i == CfgFrameWidth) width_q <= cfg_wdata_i;
        else height_q <= cfg_wdata_i;
        peak_q  <= '0;
        row_q   <= '0;
        col_q   <= '0;
        rptr_q  <= '0;
        ready_q <= 1'b0;
        held_q  <= '0;
      end
    end
  end

  assign status_o.ready    = ready_q;
  assign status_o.interior = (row_q >= DimW'(2)) && (col_q >= DimW'(2));
  assign valid_o           = valid_q;
  assign magnitude_o       = mag_q;
  assign last_o            = last_q;

endmodule

FILE: tb/tb_gradient_magnitude_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gradient magnitude normaliser testbench
// Loads frames of random and extreme pixels under changing geometry, fetches
// the rescaled magnitudes and checks each one against an in-bench model.
// ----------------------------------------------------------------------------
module tb_gradient_magnitude_normalizer;
  import gmn_pkg::*;

  // Item actions, as carried on action_i.
  localparam bit ActLoad  = 1'b0;
  localparam bit ActFetch = 1'b1;
  // A register index that the block does not decode.
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  // The slowest item is an interior pixel load; this covers it with margin.
  localparam int unsigned SettleCycles = 40;
  // Cycles without any item or result before the run is abandoned.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned RandomItems = 1600;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               action_i = 1'b0;
  logic [7:0]         pixel_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [DimW-1:0]    cfg_wdata_i = '0;
  logic               valid_o;
  logic [7:0]         magnitude_o;
  logic               last_o;

  gradient_magnitude_normalizer dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .pixel_i,
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i, .valid_o, .magnitude_o, .last_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the block: its own copy of geometry, line buffers, frame store
  // and the frame counters.
  // --------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] magnitude;
    logic       last;
  } norm_result_t;

  norm_result_t pending_results[$];
  int unsigned  fail_count = 0;

  logic [DimW-1:0] width_reg  = DimW'(256);
  logic [DimW-1:0] height_reg = DimW'(256);
  logic [7:0]  row_above [MaxCols];
  logic [7:0]  row_centre [MaxCols];
  logic [7:0]  mag_store [65536];
  int unsigned frame_peak, cur_row, cur_col, fetch_pos, prev_pixel;
  bit          frame_loaded;

  function automatic int unsigned dim_in_use(logic [DimW-1:0] raw, int unsigned maxv);
    int unsigned v;
    v = raw;
    if (v < 3) v = 3;
    if (v > maxv) v = maxv;
    return v;
  endfunction

  function automatic int unsigned int_root(int unsigned s);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= s) r++;
    return r;
  endfunction

  function automatic void restart_frame();
    frame_peak = 0;
    cur_row = 0;
    cur_col = 0;
    fetch_pos = 0;
    frame_loaded = 1'b0;
    prev_pixel = 0;
  endfunction

  function automatic void write_geometry(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    if (idx == CfgFrameWidth) begin
      width_reg = val;
      restart_frame();
    end else if (idx == CfgFrameHeight) begin
      height_reg = val;
      restart_frame();
    end
  endfunction

  // Advances the model by one accepted item; returns 1 with the result when
  // the item produces one.
  function automatic bit compute_magnitude(bit act, logic [7:0] pix,
                                           output norm_result_t res);
    int unsigned w, h, r, c, cnt, m, v, mag;
    int dx, dy;
    logic [7:0] tmp;
    w = dim_in_use(width_reg, MaxCols);
    h = dim_in_use(height_reg, MaxRows);
    cnt = (w - 2) * (h - 2);
    res = '0;
    if (act == ActLoad) begin
      // A load during the fetch phase drops the unread results.
      if (frame_loaded) begin
        frame_loaded = 1'b0;
        fetch_pos = 0;
        cur_row = 0;
        cur_col = 0;
      end
      r = cur_row;
      c = cur_col;
      if (r >= h || c >= w) begin
        r = 0;
        c = 0;
      end
      if (r == 0 && c == 0) frame_peak = 0;
      if (r >= 2 && c >= 2) begin
        dx = int'(row_centre[c]) - int'(row_centre[c - 2]);
        dy = int'(row_above[c - 1]) - int'(prev_pixel);
        m = int_root(dx * dx + dy * dy) >> 1;
        mag_store[(r - 2) * (w - 2) + (c - 2)] = m[7:0];
        if (m > frame_peak) frame_peak = m;
      end
      if (c >= 1) row_above[c - 1] = prev_pixel[7:0];
      prev_pixel = pix;
      if (c == w - 1) begin
        row_above[c] = pix;
        for (int i = 0; i < MaxCols; i++) begin
          tmp = row_centre[i];
          row_centre[i] = row_above[i];
          row_above[i] = tmp;
        end
        cur_col = 0;
        if (r == h - 1) begin
          cur_row = 0;
          frame_loaded = 1'b1;
          fetch_pos = 0;
        end else begin
          cur_row = r + 1;
        end
      end else begin
        cur_row = r;
        cur_col = c + 1;
      end
      return 1'b0;
    end
    // A fetch while the frame is still loading is ignored.
    if (!frame_loaded) return 1'b0;
    v = mag_store[fetch_pos];
    mag = (frame_peak == 0) ? 0 : (v * 255) / frame_peak;
    if (mag > 255) mag = 255;
    res.magnitude = mag[7:0];
    res.last = (fetch_pos + 1 >= cnt);
    if (res.last) begin
      frame_loaded = 1'b0;
      fetch_pos = 0;
    end else begin
      fetch_pos++;
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. Results cannot be held off, so every strobe is taken
  // at the edge that ends its cycle and compared with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    norm_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: magnitude %0d last %0d", magnitude_o, last_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (magnitude_o !== want.magnitude) begin
          $error("magnitude: expected %0d, got %0d", want.magnitude, magnitude_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // The watchdog is cleared by every accepted item and every result.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("[gradient_magnitude_normalizer] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Item driver. Items go out in bursts of random length; between bursts
  // start_i drops for a random number of cycles.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned counted_items = 0;

  task automatic send_item(bit act, logic [7:0] pix, bit typed = 1'b0,
                           norm_result_t typed_res = '0);
    norm_result_t res;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      // Some bursts are long enough to run without any gap for a while.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 20);
    end
    start_i  <= 1'b1;
    action_i <= act;
    pixel_i  <= pix;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
    counted_items++;
    if (compute_magnitude(act, pix, res)) begin
      pending_results.push_back(typed ? typed_res : res);
    end
  endtask

  // Lets every expected result arrive, then the block settle, before a
  // register is written.
  task automatic drain();
    start_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    write_geometry(idx, val);
  endtask

  // Directed rows for a 3 by 3 frame: one interior pixel whose differences
  // are both full scale, then a flat frame with a peak of zero.
  typedef struct packed {
    bit         act;
    logic [7:0] pix;
    bit         typed;
    logic [7:0] magnitude;
    bit         last;
  } stim_row_t;

  stim_row_t directed_rows [22] = '{
    '{ActFetch, 8'd0,   1'b0, 8'd0,   1'b0},  // fetch with nothing loaded
    '{ActLoad,  8'd0,   1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd255, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd0,   1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd0,   1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd77,  1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd255, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd0,   1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd0,   1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd0,   1'b0, 8'd0,   1'b0},
    '{ActFetch, 8'd0,   1'b1, 8'd255, 1'b1},  // the only value is the peak
    '{ActFetch, 8'd0,   1'b0, 8'd0,   1'b0},  // fetch after the last value
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActLoad,  8'd128, 1'b0, 8'd0,   1'b0},
    '{ActFetch, 8'd0,   1'b1, 8'd0,   1'b1}   // zero peak gives zero
  };

  // Picks a raw geometry value: mostly small, sometimes the extremes or a
  // value that the block clamps.
  function automatic logic [DimW-1:0] pick_dim(bit allow_big);
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return DimW'($urandom_range(0, 2));
    if (sel == 1 && allow_big) return DimW'($urandom_range(257, 511));
    if (sel == 2 && allow_big) return DimW'(256);
    if (sel == 3) return DimW'(3);
    return DimW'($urandom_range(3, 12));
  endfunction

  function automatic logic [7:0] pick_pixel(int unsigned style, logic [7:0] level);
    case (style)
      0: return level;
      1: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    logic [DimW-1:0] raw_w, raw_h;
    int unsigned w, h, n_load, n_fetch, style;
    logic [7:0] level;
    norm_result_t typed_res;

    restart_frame();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the smallest frame.
    write_reg(CfgFrameWidth, DimW'(3));
    write_reg(CfgFrameHeight, DimW'(3));
    foreach (directed_rows[i]) begin
      typed_res.magnitude = directed_rows[i].magnitude;
      typed_res.last = directed_rows[i].last;
      send_item(directed_rows[i].act, directed_rows[i].pix,
                directed_rows[i].typed, typed_res);
    end
    // An undecoded index leaves the geometry alone.
    write_reg(CfgUnused, DimW'(511));

    // Random phases: new geometry, then frames loaded and fetched.
    while (counted_items < RandomItems) begin
      // Only one dimension may be large at a time, to keep frames short.
      if ($urandom_range(0, 1)) begin
        raw_w = pick_dim(1'b1);
        raw_h = pick_dim(1'b0);
      end else begin
        raw_w = pick_dim(1'b0);
        raw_h = pick_dim(1'b1);
      end
      write_reg(CfgFrameWidth, raw_w);
      write_reg(CfgFrameHeight, raw_h);
      if ($urandom_range(0, 5) == 0)
        write_reg(CfgIdxW'(CfgUnused - $urandom_range(0, 1)),
                  DimW'($urandom_range(0, 511)));
      w = dim_in_use(width_reg, MaxCols);
      h = dim_in_use(height_reg, MaxRows);
      repeat ($urandom_range(1, 3)) begin
        style = $urandom_range(0, 5);
        level = 8'($urandom_range(0, 255));
        // Now and then a frame is cut short by the next geometry write.
        n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : w * h;
        for (int i = 0; i < n_load && counted_items < RandomItems; i++) begin
          if ($urandom_range(0, 19) == 0) send_item(ActFetch, 8'($urandom));
          send_item(ActLoad, pick_pixel(style, level));
        end
        // Sometimes only part of the frame is read before the next load.
        n_fetch = (w - 2) * (h - 2);
        if ($urandom_range(0, 5) == 0) n_fetch = $urandom_range(0, n_fetch);
        else if ($urandom_range(0, 5) == 0) n_fetch++;
        for (int i = 0; i < n_fetch && counted_items < RandomItems; i++)
          send_item(ActFetch, 8'($urandom));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("[gradient_magnitude_normalizer] OK");
    end else begin
      $display("[gradient_magnitude_normalizer] ERROR");
    end
    $finish;
  end

endmodule
